// ----- sv/ute_pkg.sv -----
package ute_pkg;

    // Default depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Characters used by the escape forms.
    localparam logic [7:0]   CH_BACKSLASH = 8'h5C;
    localparam logic [7:0]   CH_LOWER_X   = 8'h78;
    localparam logic [7:0]   CH_LOWER_U   = 8'h75;
    localparam logic [127:0] HEX_CHARS    = "0123456789ABCDEF";

    // What the back has to emit for one queued command.
    typedef enum logic [1:0] {
        CMD_BYTE_ESC,
        CMD_CP_ESC,
        CMD_PASS
    } t_kind;

    // One command: a single-byte escape, a code point escape or a run of raw bytes.
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  len;
        logic [31:0] data;
        logic        last;
        logic        eot;
    } t_cmd;

    // Uppercase hex digit for one nibble.
    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        logic [3:0] rev;
        rev = 4'd15 - v;
        return HEX_CHARS[{rev, 3'b000} +: 8];
    endfunction

endpackage

// ----- sv/ute_in_if.sv -----
interface ute_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ----- sv/ute_out_if.sv -----
interface ute_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       text_done;

    modport source (output valid, output out_byte, output last_of_run, output text_done,
                    input ready);
    modport sink (input valid, input out_byte, input last_of_run, input text_done,
                  output ready);
endinterface

// ----- sv/ute_front.sv -----
module ute_front import ute_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_preserve,
    ute_in_if.sink i_in,
    output logic o_push,
    output t_cmd o_cmd,
    input  logic i_full
);

    typedef logic [3:0][7:0] t_buf;

    typedef struct packed {
        logic        hold;
        t_kind       kind;
        logic [2:0]  consume;
        logic [31:0] data;
    } t_scan;

    localparam logic [20:0] CP_ALM   = 21'h00061C;
    localparam logic [20:0] CP_LRM   = 21'h00200E;
    localparam logic [20:0] CP_RLM   = 21'h00200F;
    localparam logic [20:0] CP_EMB_LO = 21'h00202A;
    localparam logic [20:0] CP_EMB_HI = 21'h00202E;
    localparam logic [20:0] CP_ISO_LO = 21'h002066;
    localparam logic [20:0] CP_ISO_HI = 21'h00206F;
    localparam logic [20:0] CP_DEL    = 21'h00007F;
    localparam logic [20:0] CP_C1_HI  = 21'h00009F;
    localparam logic [20:0] CP_SPACE  = 21'h000020;
    localparam logic [20:0] CP_LF     = 21'h00000A;
    localparam logic [20:0] CP_TAB    = 21'h000009;

    function automatic logic [7:0] byte_at(input t_buf b, input logic [2:0] idx);
        return idx[2] ? 8'h00 : b[idx[1:0]];
    endfunction

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        if (b < 8'h80) return 3'd1;
        if (b >= 8'hC2 && b <= 8'hDF) return 3'd2;
        if (b >= 8'hE0 && b <= 8'hEF) return 3'd3;
        if (b >= 8'hF0 && b <= 8'hF4) return 3'd4;
        return 3'd0;
    endfunction

    function automatic logic follower_ok(input logic [7:0] lead, input logic [1:0] i,
                                         input logic [7:0] b);
        if (b[7:6] != 2'b10) return 1'b0;
        if (i == 2'd1) begin
            if (lead == 8'hE0 && b < 8'hA0) return 1'b0;
            if (lead == 8'hED && b > 8'h9F) return 1'b0;
            if (lead == 8'hF0 && b < 8'h90) return 1'b0;
            if (lead == 8'hF4 && b > 8'h8F) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic is_control(input logic [20:0] cp, input logic preserve);
        if (cp < CP_SPACE) return !(preserve && (cp == CP_LF || cp == CP_TAB));
        return (cp >= CP_DEL && cp <= CP_C1_HI) || cp == CP_ALM || cp == CP_LRM ||
               cp == CP_RLM || (cp >= CP_EMB_LO && cp <= CP_EMB_HI) ||
               (cp >= CP_ISO_LO && cp <= CP_ISO_HI);
    endfunction

    // Classifies the sequence that starts at pos in the buffer.
    function automatic t_scan analyze(input t_buf b, input logic [2:0] n,
                                      input logic [2:0] pos, input logic eot,
                                      input logic preserve);
        logic [7:0]  first;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [2:0]  len;
        logic [2:0]  avail;
        logic        ok;
        logic [20:0] cp;
        t_scan       s;
        first = byte_at(b, pos);
        b1    = byte_at(b, pos + 3'd1);
        b2    = byte_at(b, pos + 3'd2);
        b3    = byte_at(b, pos + 3'd3);
        avail = n - pos;
        len   = lead_length(first);
        ok    = (len != 3'd0);
        if (ok && len > 3'd1 && avail > 3'd1 && !follower_ok(first, 2'd1, b1)) ok = 1'b0;
        if (ok && len > 3'd2 && avail > 3'd2 && !follower_ok(first, 2'd2, b2)) ok = 1'b0;
        if (ok && len > 3'd3 && avail > 3'd3 && !follower_ok(first, 2'd3, b3)) ok = 1'b0;
        s         = '0;
        s.kind    = CMD_BYTE_ESC;
        s.consume = 3'd1;
        s.data    = {24'h000000, first};
        cp        = '0;
        if (ok) begin
            if (len > avail) begin
                s.hold = !eot;
            end else begin
                case (len)
                    3'd1:    cp = {13'h0000, first};
                    3'd2:    cp = {10'h000, first[4:0], b1[5:0]};
                    3'd3:    cp = {5'h00, first[3:0], b1[5:0], b2[5:0]};
                    default: cp = {first[2:0], b1[5:0], b2[5:0], b3[5:0]};
                endcase
                s.consume = len;
                if (is_control(cp, preserve)) begin
                    s.kind = CMD_CP_ESC;
                    s.data = {16'h0000, cp[15:0]};
                end else begin
                    s.kind = CMD_PASS;
                    s.data = {b3, b2, b1, first};
                end
            end
        end
        return s;
    endfunction

    t_buf       r_buf;
    logic [2:0] r_n;
    logic [1:0] r_pos;
    logic       r_eot;
    logic       r_busy;
    logic [1:0] r_cnt;

    t_scan      s_cur;
    t_scan      s_next;
    logic [2:0] pos_cur;
    logic [2:0] pos_next;
    logic [2:0] start;
    logic [2:0] remain;
    logic       last;
    logic       accept;
    logic       finish;
    t_buf       n_buf;

    assign i_in.ready = !r_busy;
    assign accept     = i_in.valid && !r_busy;

    always_comb begin
        pos_cur  = {1'b0, r_pos};
        s_cur    = analyze(r_buf, r_n, pos_cur, r_eot, i_preserve);
        pos_next = pos_cur + s_cur.consume;
        s_next   = analyze(r_buf, r_n, pos_next, r_eot, i_preserve);
        // This command closes the request when nothing is left or the rest is held.
        last     = (pos_next == r_n) || s_next.hold;
        o_push   = r_busy && !s_cur.hold && !i_full;
        o_cmd    = '{kind: s_cur.kind, len: s_cur.consume, data: s_cur.data,
                     last: last, eot: r_eot};
        finish   = r_busy && (s_cur.hold || (o_push && last));
        start    = s_cur.hold ? pos_cur : pos_next;
        remain   = r_n - start;
        for (int i = 0; i < 4; i++) begin
            n_buf[i] = byte_at(r_buf, start + 3'(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 2'd0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (finish) begin
            r_busy <= 1'b0;
            r_cnt  <= remain[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf[r_cnt] <= i_in.in_byte;
            r_n          <= {1'b0, r_cnt} + 3'd1;
            r_pos        <= 2'd0;
            r_eot        <= i_in.end_of_text;
        end else if (finish) begin
            r_buf <= n_buf;
        end else if (o_push) begin
            r_pos <= pos_next[1:0];
        end
    end

endmodule

// ----- sv/ute_queue.sv -----
module ute_queue import ute_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/ute_back.sv -----
module ute_back import ute_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    ute_out_if.source o_out
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_done;

    logic [2:0] count;
    logic [7:0] n_byte;
    logic       at_end;
    logic       load;

    always_comb begin
        unique case (i_cmd.kind)
            CMD_BYTE_ESC: count = 3'd4;
            CMD_CP_ESC:   count = 3'd6;
            CMD_PASS:     count = i_cmd.len;
            default:      count = 3'd1;
        endcase
    end

    always_comb begin
        unique case (i_cmd.kind)
            CMD_BYTE_ESC: begin
                case (r_idx)
                    3'd0:    n_byte = CH_BACKSLASH;
                    3'd1:    n_byte = CH_LOWER_X;
                    3'd2:    n_byte = nibble_char(i_cmd.data[7:4]);
                    default: n_byte = nibble_char(i_cmd.data[3:0]);
                endcase
            end
            CMD_CP_ESC: begin
                case (r_idx)
                    3'd0:    n_byte = CH_BACKSLASH;
                    3'd1:    n_byte = CH_LOWER_U;
                    3'd2:    n_byte = nibble_char(i_cmd.data[15:12]);
                    3'd3:    n_byte = nibble_char(i_cmd.data[11:8]);
                    3'd4:    n_byte = nibble_char(i_cmd.data[7:4]);
                    default: n_byte = nibble_char(i_cmd.data[3:0]);
                endcase
            end
            CMD_PASS: n_byte = i_cmd.data[{r_idx[1:0], 3'b000} +: 8];
            default:  n_byte = i_cmd.data[7:0];
        endcase
    end

    assign at_end = (r_idx == count - 3'd1);
    assign load   = i_valid && (!r_valid || o_out.ready);
    assign o_pop  = load && at_end;

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.last_of_run = r_last;
    assign o_out.text_done   = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 3'd0 : r_idx + 3'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_last <= at_end && i_cmd.last;
            r_done <= at_end && i_cmd.last && i_cmd.eot;
        end
    end

endmodule

// ----- sv/utf8_terminal_escaper.sv -----
// An input byte that completes a sequence goes into the front buffer, is scanned into
// the queue and is loaded into the back output register. The front takes no new input
// byte until it has pushed all commands the last one made (one per sequence or rejected
// byte); a full queue stalls it. The back emits one output byte per cycle while it has
// a command and the output is ready. Reset (i_rst_n, synchronous, active low): nothing
// held, queue and output empty, newline and tab preserved.
module utf8_terminal_escaper import ute_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    ute_in_if.sink i_in,
    ute_out_if.source o_out
);

    // The layout mode register. When set, newline and tab pass through as
    // plain bytes; when clear they are escaped like every other C0 code.
    logic r_preserve;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preserve <= 1'b1;
        end else if (i_cfg_we) begin
            r_preserve <= i_cfg_data;
        end
    end

    // The front takes one input request at a time. It merges the byte with
    // the bytes held from earlier requests, then walks the buffer one
    // sequence per cycle while the queue has room, pushing one command per
    // sequence or rejected byte. A valid but unfinished tail is kept for the
    // next request, or escaped byte by byte if the request ends the text.
    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    ute_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_preserve (r_preserve),
        .i_in       (i_in),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_full     (q_full)
    );

    // The queue lets the front keep scanning while a long escape drains.
    ute_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    // The back expands each command into its output bytes, one per cycle while
    // the output is ready, through a registered output stage. The final byte
    // of a request's last command carries last_of_run, and text_done at text end.
    ute_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule
